// ===== sv/swmf_pkg.sv =====
// ----------------------------------------------------------------------------
// swmf_pkg
// shared constants for the sliding window median filter core
// ----------------------------------------------------------------------------
package swmf_pkg;

  localparam int unsigned DefRadius   = 5;
  localparam int unsigned DefMaxWidth = 2048;

  localparam int unsigned PixW   = 8;
  localparam int unsigned CntW   = 11;
  localparam int unsigned CfgW   = 12;
  localparam int unsigned CntLim = 2048;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 32;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_e;

  localparam logic [CfgW-1:0] FrameWidthRst  = 12'd640;
  localparam logic [CfgW-1:0] FrameHeightRst = 12'd480;

endpackage

// ===== sv/sliding_window_median_filter_core.sv =====
// ----------------------------------------------------------------------------
// sliding_window_median_filter_core
// raster stream median filter over a (2*RADIUS+1) square window, line store
// and window kept in synchronous memories
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_axis    in         tdata: pixel_in[7:0]; tuser: start_of_frame
//  m_axis    out        tdata: median_value, center_col, center_row
//  cfg       in         write enable, register index, 12-bit data
//
//  a word loads its column through the line store port; a word that yields
//  a result adds 8 passes over the window memory read port, one per result
//  bit from the top, then loads the output register.
//  one word is in work at a time.
//  reset clears counters and registers to 640 x 480; memories are not cleared.
//  a result waiting on m_axis_tready holds off the next result load, and input stalls while that load waits.
module sliding_window_median_filter_core #(
  parameter int unsigned RADIUS    = swmf_pkg::DefRadius,
  parameter int unsigned MAX_WIDTH = swmf_pkg::DefMaxWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [swmf_pkg::InDataW-1:0]  s_axis_tdata,   // pixel_in[7:0]
  input  logic                          s_axis_tuser,   // start_of_frame
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // median_value[7:0], center_col[18:8], center_row[29:19], zero[31:30]
  output logic [swmf_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [swmf_pkg::CfgW-1:0]     cfg_wdata_i
);

  import swmf_pkg::*;

  localparam int unsigned Win      = 2 * RADIUS + 1;
  localparam int unsigned NWin     = Win * Win;
  localparam int unsigned NLines   = 2 * RADIUS;
  localparam int unsigned Rank     = (NWin - 1) / 2;
  localparam int unsigned WidthCap = (MAX_WIDTH < CntLim) ? MAX_WIDTH : CntLim;
  localparam int unsigned LineD    = NLines * MAX_WIDTH;
  localparam int unsigned LaW      = $clog2(LineD);
  localparam int unsigned WaW      = $clog2(NWin);
  localparam int unsigned IdxW     = $clog2(NWin + 1);
  localparam int unsigned SlotW    = $clog2(NLines);
  localparam int unsigned WsW      = $clog2(Win);
  localparam int unsigned LcW      = $clog2(NLines + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_FIN  = 6'b000100,
    S_MED  = 6'b001000,
    S_DEC  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CfgW-1:0]  fw_q, fh_q;
  logic [CntW-1:0]  col_q, row_q;
  logic [SlotW-1:0] slot_q, rd_slot_q;
  logic [WsW-1:0]   ws_q;
  logic [LcW-1:0]   lcnt_q;
  logic [PixW-1:0]  pix_q;
  logic [IdxW-1:0]  idx_q;
  logic             rd_vld_q;
  logic [IdxW-1:0]  less_q;
  logic [PixW-1:0]  pfx_q;
  logic [2:0]       bit_q;
  logic [CntW-1:0]  ccol_q, crow_q;
  logic             out_vld_q;
  logic [PixW-1:0]  o_med_q;
  logic [CntW-1:0]  o_col_q, o_row_q;

  logic [PixW-1:0] line_mem [LineD];
  logic [PixW-1:0] win_mem  [NWin];
  logic [PixW-1:0] line_rdata_q, win_rdata_q;

  logic            accept;
  logic [CfgW-1:0] w_eff, h_eff;
  logic [LaW-1:0]  line_raddr, line_waddr;
  logic            line_we;
  logic [WaW-1:0]  win_waddr, win_raddr;
  logic            win_we, win_re;
  logic [PixW-1:0] win_wdata;
  logic [PixW-1:0] cand;
  logic            has_res;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    if (fw_q == '0) w_eff = CfgW'(1);
    else if (fw_q > CfgW'(WidthCap)) w_eff = CfgW'(WidthCap);
    else w_eff = fw_q;
    if (fh_q == '0) h_eff = CfgW'(1);
    else if (fh_q > CfgW'(CntLim)) h_eff = CfgW'(CntLim);
    else h_eff = fh_q;
  end

  assign line_raddr = LaW'(rd_slot_q) * LaW'(MAX_WIDTH) + LaW'(col_q);
  assign line_waddr = LaW'(slot_q) * LaW'(MAX_WIDTH) + LaW'(col_q);
  assign line_we    = (state_q == S_LOAD) && (lcnt_q == LcW'(NLines));

  always_comb begin
    win_we    = 1'b0;
    win_wdata = line_rdata_q;
    win_waddr = WaW'(lcnt_q - LcW'(1)) * WaW'(Win) + WaW'(ws_q);
    if (state_q == S_LOAD && lcnt_q != '0) win_we = 1'b1;
    if (state_q == S_FIN) begin
      win_we    = 1'b1;
      win_wdata = pix_q;
      win_waddr = WaW'(NLines) * WaW'(Win) + WaW'(ws_q);
    end
  end

  assign win_re    = (state_q == S_MED) && (idx_q < IdxW'(NWin));
  assign win_raddr = idx_q[WaW-1:0];
  assign cand      = pfx_q | (PixW'(1) << bit_q);
  assign has_res   = (row_q >= CntW'(NLines)) && (col_q >= CntW'(NLines));

  always_ff @(posedge clk_i) begin
    if (line_we) line_mem[line_waddr] <= pix_q;
    line_rdata_q <= line_mem[line_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (win_we) win_mem[win_waddr] <= win_wdata;
    if (win_re) win_rdata_q <= win_mem[win_raddr];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_LOAD;
      S_LOAD: if (lcnt_q == LcW'(NLines)) state_d = S_FIN;
      S_FIN:  state_d = has_res ? S_MED : S_IDLE;
      S_MED:  if (idx_q == IdxW'(NWin) && !rd_vld_q) state_d = S_DEC;
      S_DEC:  state_d = (bit_q == '0) ? S_OUT : S_MED;
      S_OUT:  if (!out_vld_q || m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fw_q      <= FrameWidthRst;
      fh_q      <= FrameHeightRst;
      col_q     <= '0;
      row_q     <= '0;
      slot_q    <= '0;
      rd_slot_q <= '0;
      ws_q      <= '0;
      lcnt_q    <= '0;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      less_q    <= '0;
      pfx_q     <= '0;
      bit_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_FRAME_WIDTH:  fw_q <= cfg_wdata_i;
          REG_FRAME_HEIGHT: fh_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (state_q == S_OUT && (!out_vld_q || m_axis_tready)) out_vld_q <= 1'b1;
      else if (out_vld_q && m_axis_tready) out_vld_q <= 1'b0;
      rd_vld_q <= win_re;
      unique case (state_q)
        S_IDLE: begin
          lcnt_q <= '0;
          if (accept) begin
            if (s_axis_tuser) begin
              col_q     <= '0;
              row_q     <= '0;
              slot_q    <= '0;
              rd_slot_q <= '0;
            end else begin
              rd_slot_q <= slot_q;
            end
          end
        end
        S_LOAD: begin
          lcnt_q    <= lcnt_q + LcW'(1);
          rd_slot_q <= (rd_slot_q == SlotW'(NLines - 1)) ? '0 : rd_slot_q + SlotW'(1);
        end
        S_FIN: begin
          ws_q   <= (ws_q == WsW'(Win - 1)) ? '0 : ws_q + WsW'(1);
          idx_q  <= '0;
          less_q <= '0;
          pfx_q  <= '0;
          bit_q  <= 3'd7;
          if ({1'b0, col_q} + CfgW'(1) >= w_eff) begin
            col_q <= '0;
            if ({1'b0, row_q} + CfgW'(1) >= h_eff) begin
              row_q  <= '0;
              slot_q <= '0;
            end else begin
              row_q  <= row_q + CntW'(1);
              slot_q <= (slot_q == SlotW'(NLines - 1)) ? '0 : slot_q + SlotW'(1);
            end
          end else begin
            col_q <= col_q + CntW'(1);
          end
        end
        S_MED: begin
          if (win_re) idx_q <= idx_q + IdxW'(1);
          if (rd_vld_q && (win_rdata_q < cand)) less_q <= less_q + IdxW'(1);
        end
        S_DEC: begin
          if (less_q <= IdxW'(Rank)) pfx_q <= cand;
          idx_q  <= '0;
          less_q <= '0;
          if (bit_q != '0) bit_q <= bit_q - 3'd1;
        end
        S_OUT: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && accept) pix_q <= s_axis_tdata[PixW-1:0];
    if (state_q == S_FIN) begin
      ccol_q <= col_q - CntW'(RADIUS);
      crow_q <= row_q - CntW'(RADIUS);
    end
    if (state_q == S_OUT && (!out_vld_q || m_axis_tready)) begin
      o_med_q <= pfx_q;
      o_col_q <= ccol_q;
      o_row_q <= crow_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, o_row_q, o_col_q, o_med_q};

  a_accept_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_LOAD) else $error("accepted word did not start load");
  a_less_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MED |-> less_q <= IdxW'(NWin)) else $error("rank count overflow");
  a_rd_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q) == S_MED) else $error("window read outside median scan");
  a_out_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && !out_vld_q) |=> out_vld_q) else $error("result not loaded");

endmodule
